FILE: rtl/sfrp_pkg.sv
// Shared types and constants for the sensor-hub frame report parser.
// No dependencies; imported by every module under rtl/.

package sfrp_pkg;

    localparam int RX_BUFFER_BYTES = 256;
    localparam int COUNTER_BITS    = 16;
    localparam int POS_BITS        = $clog2(RX_BUFFER_BYTES + 1);

    localparam int HDR_BYTES   = 4;
    localparam int TS_SKIP     = 5;
    localparam int ROT_BYTES   = 14;
    localparam int NUM_FIELDS  = 5;
    localparam logic [7:0] TS_MARK = 8'hFB;

    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CONTROL_CH    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_EXECUTABLE_CH = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_REPORT_CH     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PRODUCT_ID    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RESET_DONE    = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ROTATION_ID   = 3'd5;

    localparam int OUT_DATA_BITS = 144;

    typedef enum logic [2:0] {
        EV_IGNORED    = 3'd0,
        EV_MALFORMED  = 3'd1,
        EV_FRAGMENT   = 3'd2,
        EV_PRODUCT_ID = 3'd3,
        EV_RESET_DONE = 3'd4,
        EV_ROTATION   = 3'd5,
        EV_OTHER      = 3'd6
    } event_t;

    typedef struct packed {
        logic [7:0] control_channel;
        logic [7:0] executable_channel;
        logic [7:0] report_channel;
        logic [7:0] product_id_code;
        logic [7:0] reset_done_code;
        logic [7:0] rotation_report_id;
    } cfg_t;

    typedef struct packed {
        logic [15:0]                  length_word;
        logic [7:0]                   channel;
        logic [7:0]                   first_payload;
        logic [7:0]                   report_id;
        logic [1:0]                   status;
        logic [NUM_FIELDS-1:0][15:0]  fields;
    } frame_t;

    typedef struct packed {
        event_t                       event_res;
        logic [7:0]                   channel;
        logic [14:0]                  frame_length;
        logic                         continuation;
        logic [1:0]                   accuracy_status;
        logic [NUM_FIELDS-1:0][15:0]  fields;
        logic [15:0]                  malformed_total;
        logic [15:0]                  frame_total;
    } result_t;

endpackage

FILE: rtl/shtp_frame_report_parser.sv
// Sensor-hub transport frame parser, top level: stream ports, config registers, beat registers.
// Depends on sfrp_pkg, sfrp_frame_capture, sfrp_classify.
//
// Usage:
//   s_* carries the bytes of one read transaction, one byte per beat; s_tlast marks
//   the transaction's final byte. Only that final beat yields a result beat on m_*,
//   with the frame class in m_tuser and header fields, published rotation data and
//   saturating counters in m_tdata.
//   cfg_we/cfg_index/cfg_data write the channel and code registers; write only while
//   no transaction is in flight. Indexes past the register list are ignored.
// Timing:
//   A byte beat is held in an input register, from which it is captured and, if
//   it closes the transaction, classified into the result register. The result beat
//   is valid once the last byte has moved from the input register into the result
//   register. One byte per cycle is sustained; the only limit is a result beat still
//   waiting on m_tready when another last byte reaches the classifier.
// Reset:
//   rst_n clears all frame state, published data, counters and the fragment flag,
//   and loads the register defaults (channels 2/1/3, codes 248/1, report id 5).
// Stall:
//   While m_tready is low a waiting result holds; non-final bytes keep flowing and a
//   final byte waits in the input register, which then deasserts s_tready.

module shtp_frame_report_parser
    import sfrp_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // [7:0] data_byte
    input  logic                      s_tlast,   // last_byte
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // [7:0] channel, [22:8] frame_length, [23] continuation, [25:24] accuracy_status,
    // [41:26] quat_i, [57:42] quat_j, [73:58] quat_k, [89:74] quat_real,
    // [105:90] heading_accuracy, [121:106] malformed_total, [137:122] frame_total,
    // [143:138] zero
    output logic [OUT_DATA_BITS-1:0]  m_tdata,
    output logic [2:0]                m_tuser,   // [2:0] event_res
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [7:0]                cfg_data
);

    cfg_t       cfg_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    logic       fire;
    logic       commit;
    frame_t     frame_next;
    result_t    result;

    assign fire     = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign commit   = fire && in_last_reg;
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.control_channel    <= 8'd2;
            cfg_reg.executable_channel <= 8'd1;
            cfg_reg.report_channel     <= 8'd3;
            cfg_reg.product_id_code    <= 8'd248;
            cfg_reg.reset_done_code    <= 8'd1;
            cfg_reg.rotation_report_id <= 8'd5;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CONTROL_CH:    cfg_reg.control_channel    <= cfg_data;
                CFG_EXECUTABLE_CH: cfg_reg.executable_channel <= cfg_data;
                CFG_REPORT_CH:     cfg_reg.report_channel     <= cfg_data;
                CFG_PRODUCT_ID:    cfg_reg.product_id_code    <= cfg_data;
                CFG_RESET_DONE:    cfg_reg.reset_done_code    <= cfg_data;
                CFG_ROTATION_ID:   cfg_reg.rotation_report_id <= cfg_data;
                default: ;
            endcase
        end
    end

    // input beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    sfrp_frame_capture u_capture (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .data_byte  (in_byte_reg),
        .last_byte  (in_last_reg),
        .frame_next (frame_next)
    );

    sfrp_classify u_classify (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (commit),
        .frame  (frame_next),
        .cfg    (cfg_reg),
        .result (result)
    );

    // result beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (commit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (commit)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.event_res;
    assign m_tdata  = {6'd0,
                       out_reg.frame_total,
                       out_reg.malformed_total,
                       out_reg.fields,
                       out_reg.accuracy_status,
                       out_reg.continuation,
                       out_reg.frame_length,
                       out_reg.channel};

endmodule

FILE: rtl/sfrp_frame_capture.sv
// Per-transaction byte capture: header, first payload byte and rotation report fields.
// Depends on sfrp_pkg.

module sfrp_frame_capture
    import sfrp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output frame_t     frame_next
);

    logic [POS_BITS-1:0] pos_reg;
    logic [POS_BITS-1:0] pos_next;
    frame_t              frame_reg;
    logic [POS_BITS-1:0] off;
    logic [POS_BITS-1:0] rel;
    logic                in_buf;

    assign in_buf = pos_reg < POS_BITS'(RX_BUFFER_BYTES);

    always_comb
    begin
        frame_next = frame_reg;
        off        = POS_BITS'(HDR_BYTES);
        rel        = '0;
        if (in_buf)
        begin
            case (pos_reg)
                POS_BITS'(0): frame_next.length_word[7:0]  = data_byte;
                POS_BITS'(1): frame_next.length_word[15:8] = data_byte;
                POS_BITS'(2): frame_next.channel           = data_byte;
                POS_BITS'(4): frame_next.first_payload     = data_byte;
                default: ;
            endcase
            if (frame_next.first_payload == TS_MARK)
                off = POS_BITS'(HDR_BYTES + TS_SKIP);
            if (pos_reg >= off)
            begin
                rel = pos_reg - off;
                if (rel == POS_BITS'(0))
                    frame_next.report_id = data_byte;
                if (rel == POS_BITS'(2))
                    frame_next.status = data_byte[1:0];
                for (int i = 0; i < NUM_FIELDS; i++)
                begin
                    if (rel == POS_BITS'(4 + 2 * i))
                        frame_next.fields[i][7:0] = data_byte;
                    if (rel == POS_BITS'(5 + 2 * i))
                        frame_next.fields[i][15:8] = data_byte;
                end
            end
        end
    end

    assign pos_next = in_buf ? pos_reg + POS_BITS'(1) : pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            frame_reg <= '0;
        end
        else if (fire)
        begin
            if (last_byte)
            begin
                pos_reg   <= '0;
                frame_reg <= '0;
            end
            else
            begin
                pos_reg   <= pos_next;
                frame_reg <= frame_next;
            end
        end
    end

endmodule

FILE: rtl/sfrp_classify.sv
// End-of-transaction classification, published rotation data, fragment flag, counters.
// Depends on sfrp_pkg.

module sfrp_classify
    import sfrp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    commit,
    input  frame_t  frame,
    input  cfg_t    cfg,
    output result_t result
);

    logic                        discarding_reg;
    logic                        discarding_next;
    logic [COUNTER_BITS-1:0]     malformed_reg;
    logic [COUNTER_BITS-1:0]     malformed_next;
    logic [COUNTER_BITS-1:0]     frames_reg;
    logic [COUNTER_BITS-1:0]     frames_next;
    logic [1:0]                  pub_status_reg;
    logic [1:0]                  pub_status_next;
    logic [NUM_FIELDS-1:0][15:0] pub_fields_reg;
    logic [NUM_FIELDS-1:0][15:0] pub_fields_next;

    logic [14:0] len;
    logic        cont;
    logic [4:0]  off;
    logic [4:0]  rot_end;
    event_t      ev;

    function automatic logic [COUNTER_BITS-1:0] sat_inc(input logic [COUNTER_BITS-1:0] v);
        return (&v) ? v : v + COUNTER_BITS'(1);
    endfunction

    assign len     = frame.length_word[14:0];
    assign cont    = frame.length_word[15];
    assign off     = (frame.first_payload == TS_MARK) ? 5'(HDR_BYTES + TS_SKIP) : 5'(HDR_BYTES);
    assign rot_end = off + 5'(ROT_BYTES);

    always_comb
    begin
        discarding_next = discarding_reg;
        malformed_next  = malformed_reg;
        frames_next     = frames_reg;
        pub_status_next = pub_status_reg;
        pub_fields_next = pub_fields_reg;
        ev              = EV_OTHER;
        if (len < 15'(HDR_BYTES) || len > 15'(RX_BUFFER_BYTES))
        begin
            malformed_next = sat_inc(malformed_reg);
            ev             = EV_MALFORMED;
        end
        else
        begin
            frames_next = sat_inc(frames_reg);
            if (discarding_reg || cont)
            begin
                discarding_next = cont;
                ev              = EV_FRAGMENT;
            end
            else if (len == 15'(HDR_BYTES))
                ev = EV_IGNORED;
            else if (frame.channel == cfg.control_channel &&
                     frame.first_payload == cfg.product_id_code)
                ev = EV_PRODUCT_ID;
            else if (frame.channel == cfg.executable_channel &&
                     frame.first_payload == cfg.reset_done_code)
                ev = EV_RESET_DONE;
            else if (frame.channel == cfg.report_channel &&
                     15'(off) < len && frame.report_id == cfg.rotation_report_id)
            begin
                if (len < 15'(rot_end))
                begin
                    malformed_next = sat_inc(malformed_reg);
                    ev             = EV_MALFORMED;
                end
                else
                begin
                    pub_status_next = frame.status;
                    pub_fields_next = frame.fields;
                    ev              = EV_ROTATION;
                end
            end
        end
    end

    always_comb
    begin
        result.event_res       = ev;
        result.channel         = frame.channel;
        result.frame_length    = len;
        result.continuation    = cont;
        result.accuracy_status = pub_status_next;
        result.fields          = pub_fields_next;
        result.malformed_total = 16'(malformed_next);
        result.frame_total     = 16'(frames_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            discarding_reg <= 1'b0;
            malformed_reg  <= '0;
            frames_reg     <= '0;
            pub_status_reg <= '0;
            pub_fields_reg <= '0;
        end
        else if (commit)
        begin
            discarding_reg <= discarding_next;
            malformed_reg  <= malformed_next;
            frames_reg     <= frames_next;
            pub_status_reg <= pub_status_next;
            pub_fields_reg <= pub_fields_next;
        end
    end

endmodule
